FILE: rtl/sls_pkg.sv
// Shared types, constants and helper functions of the 4x4 linear system solver.
// Depends on nothing; every other file but sls_chan_if imports it.
package sls_pkg;

  localparam int DIM        = 4;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WORK_W     = 48;
  localparam int HALF_W     = WORK_W / 2;
  localparam int DIV_W      = WORK_W + FRAC_BITS;
  localparam int IDX_W      = $clog2(DIM);
  localparam int CNT_W      = IDX_W + 1;
  localparam int THR_W      = 16;

  typedef logic signed [WORK_W-1:0]     work_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam work_t WORK_LIM = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic signed [WORK_W:0] LIM_X = {2'b00, {(WORK_W-1){1'b1}}};

  typedef struct packed {
    data_t col_elem0;
    data_t col_elem1;
    data_t col_elem2;
    data_t col_elem3;
    data_t rhs_elem;
  } in_req_t;

  typedef struct packed {
    data_t sol0;
    data_t sol1;
    data_t sol2;
    data_t sol3;
    logic  singular;
    logic  overflow;
  } out_req_t;

  typedef logic [THR_W-1:0] cfg_req_t;

  typedef struct packed {
    logic  start;
    logic  is_div;
    work_t a;
    work_t b;
  } lane_cmd_t;

  typedef struct packed {
    logic  done;
    logic  ovf;
    work_t res;
  } lane_rsp_t;

  typedef struct packed {
    logic  ovf;
    work_t val;
  } sat_t;

  function automatic logic [WORK_W-1:0] mag(work_t v);
    return v[WORK_W-1] ? WORK_W'(-v) : WORK_W'(v);
  endfunction

  function automatic sat_t sat_sub(work_t a, work_t b);
    logic signed [WORK_W:0] d;
    sat_t s;
    d = {a[WORK_W-1], a} - {b[WORK_W-1], b};
    s.ovf = 1'b0;
    s.val = d[WORK_W-1:0];
    if (d > LIM_X) begin
      s.ovf = 1'b1;
      s.val = WORK_LIM;
    end else if (d < -LIM_X) begin
      s.ovf = 1'b1;
      s.val = -WORK_LIM;
    end
    return s;
  endfunction

endpackage

FILE: rtl/sls_chan_if.sv
// Valid/ready channel carrying one request of payload type T.
// Depends on nothing; payload types come from sls_pkg at instantiation.
interface sls_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sls_lane.sv
// One solver lane: sequential 48-bit fixed-point multiplier (four 24x24 partial
// products) and restoring divider (one quotient bit per cycle). Uses sls_pkg.
module sls_lane import sls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_cmd_t cmd_i,
  output lane_rsp_t rsp_o
);

  typedef enum logic [1:0] {L_IDLE, L_RUN, L_FIN} lane_state_e;

  localparam int STEP_W    = $clog2(DIV_W);
  localparam int MUL_STEPS = 4;
  localparam int MQ_W      = 2 * WORK_W - FRAC_BITS;

  lane_state_e         state_q;
  logic [STEP_W-1:0]   step_q;
  logic                done_q;
  logic                div_q, neg_q, ovf_q;
  logic [WORK_W-1:0]   ua_q, ub_q, rem_q;
  logic [2*WORK_W-1:0] acc_q;
  logic [DIV_W-1:0]    dq_q;
  work_t               res_q;

  logic [HALF_W-1:0]   ah, bh;
  logic [2*HALF_W-1:0] pp;
  logic [2*WORK_W-1:0] pp_sh;
  logic [WORK_W:0]     rem_sh;
  logic                ge;
  logic [WORK_W-1:0]   rem_nx;
  logic [MQ_W-1:0]     mq;
  logic                big;
  logic [WORK_W-1:0]   qmag;
  work_t               res_d;

  always_comb begin
    ah     = step_q[0] ? ua_q[WORK_W-1:HALF_W] : ua_q[HALF_W-1:0];
    bh     = step_q[1] ? ub_q[WORK_W-1:HALF_W] : ub_q[HALF_W-1:0];
    pp     = ah * bh;
    pp_sh  = (2*WORK_W)'(pp) << (HALF_W * (int'(step_q[0]) + int'(step_q[1])));
    rem_sh = {rem_q, dq_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, ub_q};
    rem_nx = ge ? WORK_W'(rem_sh - {1'b0, ub_q}) : rem_sh[WORK_W-1:0];
    mq     = acc_q[2*WORK_W-1:FRAC_BITS];
    if (div_q) begin
      big  = |dq_q[DIV_W-1:WORK_W-1];
      qmag = {1'b0, dq_q[WORK_W-2:0]};
    end else begin
      big  = |mq[MQ_W-1:WORK_W-1];
      qmag = {1'b0, mq[WORK_W-2:0]};
    end
    if (big) begin
      qmag = WORK_LIM;
    end
    res_d = neg_q ? -work_t'(qmag) : work_t'(qmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (cmd_i.start) begin
            step_q  <= cmd_i.is_div ? STEP_W'(DIV_W - 1) : STEP_W'(MUL_STEPS - 1);
            state_q <= L_RUN;
          end
        end
        L_RUN: begin
          if (step_q == '0) begin
            state_q <= L_FIN;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        L_FIN: begin
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          ua_q  <= mag(cmd_i.a);
          ub_q  <= mag(cmd_i.b);
          neg_q <= cmd_i.a[WORK_W-1] ^ cmd_i.b[WORK_W-1];
          div_q <= cmd_i.is_div;
          acc_q <= '0;
          rem_q <= '0;
          dq_q  <= {mag(cmd_i.a), {FRAC_BITS{1'b0}}};
        end
      end
      L_RUN: begin
        if (div_q) begin
          rem_q <= rem_nx;
          dq_q  <= {dq_q[DIV_W-2:0], ge};
        end else begin
          acc_q <= acc_q + pp_sh;
        end
      end
      L_FIN: begin
        res_q <= res_d;
        ovf_q <= big;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: rtl/sls_pivot.sv
// Merging stage: picks the pivot row of one column from the lanes' entries and
// flags a pivot at or below the threshold. Registered outputs. Uses sls_pkg.
module sls_pivot import sls_pkg::*; (
  input  logic             clk_i,
  input  work_t            col_i [DIM],
  input  logic [IDX_W-1:0] p_i,
  input  logic [THR_W-1:0] thr_i,
  output logic [IDX_W-1:0] best_o,
  output logic             singular_o
);

  logic [IDX_W-1:0]  best;
  logic [WORK_W-1:0] bm;

  always_comb begin
    best = p_i;
    bm   = mag(col_i[p_i]);
    for (int r = 0; r < DIM; r++) begin
      if (IDX_W'(r) > p_i && mag(col_i[r]) > bm) begin
        best = IDX_W'(r);
        bm   = mag(col_i[r]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_o     <= best;
    singular_o <= bm <= WORK_W'(thr_i);
  end

endmodule

FILE: rtl/small_linear_system_solver.sv
// Top level of the 4x4 solver: column loading, elimination and back
// substitution sequencer. Uses sls_pkg, sls_chan_if, sls_lane and sls_pivot.
//
//   channel | dir | payload                                   | handshake
//   in_i    | in  | col_elem0..3, rhs_elem (one column)       | valid/ready
//   out_o   | out | sol0..3, singular, overflow               | valid/ready
//   cfg_i   | in  | pivot_threshold                           | valid/ready
//
// Four column requests load one per valid cycle; the solve is then paced by
// the restoring dividers (64 steps each, seven in series).
// Row lanes divide and multiply-accumulate in parallel during elimination.
// Reset clears control state, the threshold and out_q only. A result waiting
// on out_o stalls only the end of the next solve; loading continues meanwhile.
module small_linear_system_solver import sls_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  sls_chan_if.sink    in_i,
  sls_chan_if.source  out_o,
  sls_chan_if.sink    cfg_i
);

  typedef enum logic [3:0] {
    S_LOAD, S_PIV, S_SWAP, S_DIV_GO, S_DIV_WAIT, S_ELIM_GO, S_ELIM_WAIT,
    S_BMUL_GO, S_BMUL_WAIT, S_BSUB, S_BDIV_GO, S_BDIV_WAIT, S_FINAL
  } state_e;

  localparam work_t DMAX = {{(WORK_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam work_t DMIN = -DMAX - work_t'(1);

  state_e           state_q;
  logic [IDX_W-1:0] load_q, p_q, r_q;
  logic [CNT_W-1:0] c_q;
  logic             ovf_q, sing_q, out_valid_q;
  logic [THR_W-1:0] thr_q;
  out_req_t         out_q;

  work_t m_q [DIM][DIM];
  work_t v_q [DIM];
  work_t x_q [DIM];
  work_t f_q [DIM];
  work_t s_q;

  lane_cmd_t        cmd [DIM];
  lane_rsp_t        rsp [DIM];
  work_t            piv_col [DIM];
  work_t            in_col [DIM];
  logic [IDX_W-1:0] piv_best;
  logic             piv_sing;
  sat_t             elim_sat [DIM];
  sat_t             bsub_sat;
  logic             lane_ovf, elim_ovf, clamp_ovf, in_acc, last_done;
  data_t            sol_c [DIM];
  logic [IDX_W-1:0] c_idx;

  assign in_acc = in_i.valid && in_i.ready;
  assign c_idx  = c_q[IDX_W-1:0];

  assign in_col[0] = work_t'(in_i.data.col_elem0);
  assign in_col[1] = work_t'(in_i.data.col_elem1);
  assign in_col[2] = work_t'(in_i.data.col_elem2);
  assign in_col[3] = work_t'(in_i.data.col_elem3);

  always_comb begin
    for (int l = 0; l < DIM; l++) begin
      piv_col[l] = m_q[l][p_q];
      cmd[l]     = '0;
      case (state_q)
        S_DIV_GO: begin
          if (IDX_W'(l) > p_q) begin
            cmd[l].start  = 1'b1;
            cmd[l].is_div = 1'b1;
            cmd[l].a      = m_q[l][p_q];
            cmd[l].b      = m_q[p_q][p_q];
          end
        end
        S_ELIM_GO: begin
          if (IDX_W'(l) > p_q) begin
            cmd[l].start = 1'b1;
            cmd[l].a     = f_q[l];
            cmd[l].b     = (c_q == CNT_W'(DIM)) ? v_q[p_q] : m_q[p_q][c_idx];
          end
        end
        S_BMUL_GO: begin
          if (IDX_W'(l) > r_q) begin
            cmd[l].start = 1'b1;
            cmd[l].a     = m_q[r_q][l];
            cmd[l].b     = x_q[l];
          end
        end
        S_BDIV_GO: begin
          if (IDX_W'(l) == r_q) begin
            cmd[l].start  = 1'b1;
            cmd[l].is_div = 1'b1;
            cmd[l].a      = s_q;
            cmd[l].b      = m_q[r_q][r_q];
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_lane
    sls_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .rsp_o  (rsp[g])
    );
  end

  sls_pivot u_pivot (
    .clk_i      (clk_i),
    .col_i      (piv_col),
    .p_i        (p_q),
    .thr_i      (thr_q),
    .best_o     (piv_best),
    .singular_o (piv_sing)
  );

  always_comb begin
    lane_ovf = 1'b0;
    elim_ovf = 1'b0;
    for (int l = 0; l < DIM; l++) begin
      elim_sat[l] = sat_sub((c_q == CNT_W'(DIM)) ? v_q[l] : m_q[l][c_idx], rsp[l].res);
      if (state_q == S_BMUL_WAIT) begin
        if (IDX_W'(l) > r_q) lane_ovf = lane_ovf | rsp[l].ovf;
      end else if (IDX_W'(l) > p_q) begin
        lane_ovf = lane_ovf | rsp[l].ovf;
        elim_ovf = elim_ovf | elim_sat[l].ovf;
      end
    end
    bsub_sat  = sat_sub(s_q, rsp[c_idx].res);
    last_done = (state_q == S_BDIV_WAIT) ? rsp[r_q].done : rsp[DIM-1].done;
    clamp_ovf = 1'b0;
    for (int l = 0; l < DIM; l++) begin
      if (x_q[l] > DMAX) begin
        sol_c[l]  = DATA_WIDTH'(DMAX);
        clamp_ovf = 1'b1;
      end else if (x_q[l] < DMIN) begin
        sol_c[l]  = DATA_WIDTH'(DMIN);
        clamp_ovf = 1'b1;
      end else begin
        sol_c[l] = DATA_WIDTH'(x_q[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_q      <= '0;
      p_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      ovf_q       <= 1'b0;
      sing_q      <= 1'b0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
      if (out_valid_q && out_o.ready && state_q != S_FINAL) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (load_q == IDX_W'(DIM - 1)) begin
              load_q  <= '0;
              p_q     <= '0;
              ovf_q   <= 1'b0;
              sing_q  <= 1'b0;
              state_q <= S_PIV;
            end else begin
              load_q <= load_q + 1'b1;
            end
          end
        end
        S_PIV: state_q <= S_SWAP;
        S_SWAP: begin
          if (piv_sing) begin
            sing_q  <= 1'b1;
            state_q <= S_FINAL;
          end else if (p_q == IDX_W'(DIM - 1)) begin
            r_q     <= IDX_W'(DIM - 1);
            state_q <= S_BDIV_GO;
          end else begin
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (last_done) begin
            ovf_q   <= ovf_q | lane_ovf;
            c_q     <= CNT_W'(p_q) + 1'b1;
            state_q <= S_ELIM_GO;
          end
        end
        S_ELIM_GO: state_q <= S_ELIM_WAIT;
        S_ELIM_WAIT: begin
          if (last_done) begin
            ovf_q <= ovf_q | lane_ovf | elim_ovf;
            if (c_q == CNT_W'(DIM)) begin
              p_q     <= p_q + 1'b1;
              state_q <= S_PIV;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_ELIM_GO;
            end
          end
        end
        S_BMUL_GO: state_q <= S_BMUL_WAIT;
        S_BMUL_WAIT: begin
          if (last_done) begin
            ovf_q   <= ovf_q | lane_ovf;
            c_q     <= CNT_W'(r_q) + 1'b1;
            state_q <= S_BSUB;
          end
        end
        S_BSUB: begin
          ovf_q <= ovf_q | bsub_sat.ovf;
          if (c_q == CNT_W'(DIM - 1)) begin
            state_q <= S_BDIV_GO;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        S_BDIV_GO: state_q <= S_BDIV_WAIT;
        S_BDIV_WAIT: begin
          if (last_done) begin
            ovf_q <= ovf_q | rsp[r_q].ovf;
            if (r_q == '0) begin
              state_q <= S_FINAL;
            end else begin
              r_q     <= r_q - 1'b1;
              state_q <= S_BMUL_GO;
            end
          end
        end
        S_FINAL: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q    <= 1'b1;
            out_q.sol0     <= sing_q ? '0 : sol_c[0];
            out_q.sol1     <= sing_q ? '0 : sol_c[1];
            out_q.sol2     <= sing_q ? '0 : sol_c[2];
            out_q.sol3     <= sing_q ? '0 : sol_c[3];
            out_q.singular <= sing_q;
            out_q.overflow <= !sing_q && (ovf_q || clamp_ovf);
            state_q        <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          for (int l = 0; l < DIM; l++) begin
            m_q[l][load_q] <= in_col[l];
          end
          v_q[load_q] <= -work_t'(in_i.data.rhs_elem);
        end
      end
      S_SWAP: begin
        if (!piv_sing && piv_best != p_q) begin
          m_q[p_q]      <= m_q[piv_best];
          m_q[piv_best] <= m_q[p_q];
          v_q[p_q]      <= v_q[piv_best];
          v_q[piv_best] <= v_q[p_q];
        end
        if (p_q == IDX_W'(DIM - 1)) begin
          s_q <= v_q[DIM-1];
        end
      end
      S_DIV_WAIT: begin
        if (last_done) begin
          for (int l = 0; l < DIM; l++) begin
            if (IDX_W'(l) > p_q) f_q[l] <= rsp[l].res;
          end
        end
      end
      S_ELIM_WAIT: begin
        if (last_done) begin
          for (int l = 0; l < DIM; l++) begin
            if (IDX_W'(l) > p_q) begin
              if (c_q == CNT_W'(DIM)) begin
                v_q[l] <= elim_sat[l].val;
              end else begin
                m_q[l][c_idx] <= elim_sat[l].val;
              end
            end
          end
        end
      end
      S_BMUL_WAIT: begin
        if (last_done) s_q <= v_q[r_q];
      end
      S_BSUB: s_q <= bsub_sat.val;
      S_BDIV_WAIT: begin
        if (last_done) x_q[r_q] <= rsp[r_q].res;
      end
      default: ;
    endcase
  end

  assign in_i.ready  = (state_q == S_LOAD);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: rtl/sls_checker.sv
// Port-level checker of the solver, bound to the top level.
// Uses sls_pkg for the dimension and the result request type.
module sls_checker import sls_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input out_req_t out_data_i
);

  logic [IDX_W-1:0] cnt_q;
  logic             in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      cnt_q <= (cnt_q == IDX_W'(DIM - 1)) ? '0 : cnt_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result request changed while stalled");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.singular |-> out_data_i.sol0 == '0 &&
    out_data_i.sol1 == '0 && out_data_i.sol2 == '0 && out_data_i.sol3 == '0 &&
    !out_data_i.overflow)
    else $error("singular result is not cleared");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == IDX_W'(DIM - 1) |=> !in_ready_i)
    else $error("column accepted while solving");

  a_result_after_solve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a solve");

endmodule

bind small_linear_system_solver sls_checker u_sls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
